// ===== hdl/bcrc_pkg.sv =====
// ============================================================================
// bcrc_pkg
// Shared types and constants of the block copy run coalescer.
// ============================================================================
package bcrc_pkg;

    localparam int ADDR_W    = 48;
    localparam int ID_W      = 16;
    localparam int BB_W      = 25;
    localparam int LAYER_W   = 8;
    localparam int RUN_W     = 13;   // holds a run of up to 4096 blocks
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;
    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;

    localparam logic [BB_W-1:0] BLOCK_BYTES_RST = BB_W'(4096);

    typedef enum logic [2:0] {
        REG_SWAP_OUT     = 3'd0,
        REG_BLOCK_BYTES  = 3'd1,
        REG_DEVICE_LAYER = 3'd2,
        REG_HOST_LAYER   = 3'd3,
        REG_KEY_DEV_BASE = 3'd4,
        REG_VAL_DEV_BASE = 3'd5,
        REG_KEY_HST_BASE = 3'd6,
        REG_VAL_HST_BASE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [ID_W-1:0] source_id;
        logic [ID_W-1:0] target_id;
        logic            final_pair;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] byte_count;
        logic              is_value;
        logic              list_done;
        logic              item_last;
    } t_out_item;

    typedef struct packed {
        logic                  swap_out;
        logic [BB_W-1:0]       block_bytes;
        logic [LAYER_W-1:0]    device_layer;
        logic [LAYER_W-1:0]    host_layer;
        logic [ADDR_W-1:0]     key_device_base;
        logic [ADDR_W-1:0]     value_device_base;
        logic [ADDR_W-1:0]     key_host_base;
        logic [ADDR_W-1:0]     value_host_base;
    } t_cfg;

    // One finished segment, waiting to be turned into key/value descriptors.
    typedef struct packed {
        logic [ID_W-1:0]  src_id;
        logic [ID_W-1:0]  tgt_id;
        logic [RUN_W-1:0] len;
        logic             done;
        logic             last;
    } t_seg;

    typedef struct packed {
        logic [1:0] cnt;     // segments written this cycle: 0, 1 or 2
        t_seg       first;
        t_seg       second;
    } t_push;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               room;      // space for two segments
        logic               nonempty;
    } t_qstat;

endpackage

// ===== hdl/bcrc_front.sv =====
// ============================================================================
// bcrc_front
// Run tracker: accepts id pairs, extends or closes segments, queues them.
// ============================================================================
module bcrc_front
    import bcrc_pkg::*;
#(
    parameter int MAX_RUN_BLOCKS = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_push    o_push
);

    logic             r_open;
    logic [ID_W-1:0]  r_src_start;
    logic [ID_W-1:0]  r_tgt_start;
    logic [RUN_W-1:0] r_len;

    logic [ID_W:0]    src_expect;
    logic [ID_W:0]    tgt_expect;
    logic             extend;
    t_seg             old_seg;
    t_seg             fin_seg;

    assign src_expect = {1'b0, r_src_start} + (ID_W+1)'(r_len);
    assign tgt_expect = {1'b0, r_tgt_start} + (ID_W+1)'(r_len);

    assign extend = r_open
                 && (src_expect == {1'b0, i_item.source_id})
                 && (tgt_expect == {1'b0, i_item.target_id})
                 && (r_len < RUN_W'(MAX_RUN_BLOCKS));

    always_comb begin
        old_seg.src_id = r_src_start;
        old_seg.tgt_id = r_tgt_start;
        old_seg.len    = r_len;
        old_seg.done   = 1'b0;
        old_seg.last   = !i_item.final_pair;

        fin_seg.src_id = extend ? r_src_start : i_item.source_id;
        fin_seg.tgt_id = extend ? r_tgt_start : i_item.target_id;
        fin_seg.len    = extend ? r_len + RUN_W'(1) : RUN_W'(1);
        fin_seg.done   = 1'b1;
        fin_seg.last   = 1'b1;

        o_push.cnt    = 2'd0;
        o_push.first  = old_seg;
        o_push.second = fin_seg;
        if (i_accept) begin
            if (!extend && r_open) begin
                o_push.cnt = i_item.final_pair ? 2'd2 : 2'd1;
            end else if (i_item.final_pair) begin
                o_push.cnt   = 2'd1;
                o_push.first = fin_seg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_src_start <= '0;
            r_tgt_start <= '0;
            r_len       <= '0;
        end else if (i_accept) begin
            if (i_item.final_pair) begin
                r_open      <= 1'b0;
                r_src_start <= '0;
                r_tgt_start <= '0;
                r_len       <= '0;
            end else if (extend) begin
                r_len <= r_len + RUN_W'(1);
            end else begin
                r_open      <= 1'b1;
                r_src_start <= i_item.source_id;
                r_tgt_start <= i_item.target_id;
                r_len       <= RUN_W'(1);
            end
        end
    end

endmodule

// ===== hdl/bcrc_queue.sv =====
// ============================================================================
// bcrc_queue
// Segment queue between front and back; takes up to two writes per cycle.
// ============================================================================
module bcrc_queue
    import bcrc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_seg   o_head,
    output t_qstat o_stat
);

    t_seg               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic [Q_PTR_W-1:0] wr_ptr_1;

    assign wr_ptr_1 = r_wr_ptr + Q_PTR_W'(1);
    assign n_count  = r_count + Q_CNT_W'(i_push.cnt) - Q_CNT_W'(i_pop);

    assign o_head          = r_mem[r_rd_ptr];
    assign o_stat.count    = r_count;
    assign o_stat.room     = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign o_stat.nonempty = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_PTR_W'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + Q_PTR_W'(i_pop);
            r_count  <= n_count;
        end
    end

endmodule

// ===== hdl/bcrc_back.sv =====
// ============================================================================
// bcrc_back
// Descriptor builder: block index, offset multiply, then key/value issue.
// ============================================================================
module bcrc_back
    import bcrc_pkg::*;
#(
    parameter int DEVICE_BLOCKS_PER_LAYER = 4096,
    parameter int HOST_BLOCKS_PER_LAYER   = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_seg      i_head,
    input  logic      i_nonempty,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int BPL_MAX = (DEVICE_BLOCKS_PER_LAYER > HOST_BLOCKS_PER_LAYER)
                           ? DEVICE_BLOCKS_PER_LAYER : HOST_BLOCKS_PER_LAYER;
    localparam int BLK_W   = $clog2(((1 << LAYER_W) - 1) * BPL_MAX + (1 << ID_W));
    localparam int PROD_W  = BLK_W + BB_W;
    localparam int CNT_W   = RUN_W + BB_W;

    // stage 1: absolute block index on each side
    logic             r1_valid;
    logic [BLK_W-1:0] r1_dst_blk;
    logic [BLK_W-1:0] r1_src_blk;
    logic [RUN_W-1:0] r1_len;
    logic             r1_done;
    logic             r1_last;

    // stage 2: byte offsets, held for the key and the value descriptor
    logic              r2_valid;
    logic              r2_phase;
    logic [ADDR_W-1:0] r2_dst_off;
    logic [ADDR_W-1:0] r2_src_off;
    logic [ADDR_W-1:0] r2_bytes;
    logic              r2_done;
    logic              r2_last;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [BLK_W-1:0]  dev_layer_blk;
    logic [BLK_W-1:0]  hst_layer_blk;
    logic [BLK_W-1:0]  n_dst_blk;
    logic [BLK_W-1:0]  n_src_blk;
    logic [PROD_W-1:0] dst_prod;
    logic [PROD_W-1:0] src_prod;
    logic [CNT_W-1:0]  cnt_prod;
    logic [ADDR_W-1:0] dst_base;
    logic [ADDR_W-1:0] src_base;
    logic              out_load;
    logic              s2_take;
    logic              s1_free;

    assign out_load = r2_valid && (!r_out_valid || !i_stall);
    assign s2_take  = r1_valid && (!r2_valid || (out_load && r2_phase));
    assign s1_free  = !r1_valid || s2_take;
    assign o_pop    = s1_free && i_nonempty;

    assign dev_layer_blk = BLK_W'(i_cfg.device_layer) * BLK_W'(DEVICE_BLOCKS_PER_LAYER);
    assign hst_layer_blk = BLK_W'(i_cfg.host_layer) * BLK_W'(HOST_BLOCKS_PER_LAYER);

    // target id always lands at the destination; swap_out picks which side is device
    assign n_dst_blk = (i_cfg.swap_out ? hst_layer_blk : dev_layer_blk)
                     + BLK_W'(i_head.tgt_id);
    assign n_src_blk = (i_cfg.swap_out ? dev_layer_blk : hst_layer_blk)
                     + BLK_W'(i_head.src_id);

    assign dst_prod = PROD_W'(r1_dst_blk) * PROD_W'(i_cfg.block_bytes);
    assign src_prod = PROD_W'(r1_src_blk) * PROD_W'(i_cfg.block_bytes);
    assign cnt_prod = CNT_W'(r1_len) * CNT_W'(i_cfg.block_bytes);

    always_comb begin
        if (i_cfg.swap_out) begin
            dst_base = r2_phase ? i_cfg.value_host_base   : i_cfg.key_host_base;
            src_base = r2_phase ? i_cfg.value_device_base : i_cfg.key_device_base;
        end else begin
            dst_base = r2_phase ? i_cfg.value_device_base : i_cfg.key_device_base;
            src_base = r2_phase ? i_cfg.value_host_base   : i_cfg.key_host_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r1_dst_blk <= n_dst_blk;
            r1_src_blk <= n_src_blk;
            r1_len     <= i_head.len;
            r1_done    <= i_head.done;
            r1_last    <= i_head.last;
        end
        if (s2_take) begin
            r2_dst_off <= ADDR_W'(dst_prod);
            r2_src_off <= ADDR_W'(src_prod);
            r2_bytes   <= ADDR_W'(cnt_prod);
            r2_done    <= r1_done;
            r2_last    <= r1_last;
        end
        if (out_load) begin
            r_out.dest_addr  <= dst_base + r2_dst_off;
            r_out.src_addr   <= src_base + r2_src_off;
            r_out.byte_count <= r2_bytes;
            r_out.is_value   <= r2_phase;
            r_out.list_done  <= r2_done && r2_phase;
            r_out.item_last  <= r2_last && r2_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r2_phase    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r1_valid <= 1'b1;
            end else if (s2_take) begin
                r1_valid <= 1'b0;
            end

            if (s2_take) begin
                r2_valid <= 1'b1;
                r2_phase <= 1'b0;
            end else if (out_load) begin
                r2_valid <= !r2_phase;
                r2_phase <= 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== hdl/block_copy_run_coalescer_top.sv =====
// ============================================================================
// block_copy_run_coalescer_top
// Merges runs of consecutive block copy pairs into key/value DMA descriptors.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall / i_item): one (source, target) block id
//   pair per transaction; final_pair marks the end of a list. Pairs whose ids
//   both step up by one extend the open segment (up to MAX_RUN_BLOCKS blocks).
//   Output channel (o_valid / i_stall / o_item): copy descriptors, key then
//   value, one per transaction. A pair produces 0, 2 or 4 descriptors.
//   APB port: eight 64-bit registers at byte address 8*index; write them
//   only while the block is idle.
// Timing:
//   One pair per cycle is accepted while o_stall is low. A finished segment
//   sits in a 4-entry queue; its key descriptor then passes through stage 1,
//   stage 2 and the output register, and the value descriptor follows it.
//   The back end issues one descriptor per cycle unless i_stall holds it.
//   o_stall rises when the queue has fewer than two free entries.
// Reset: clears the run tracker, queue pointers, pipeline valids and the
//   registers to their defaults (block_bytes 4096, everything else 0).
// Stall: a held descriptor stays on o_item; the pipeline and then the queue
//   fill and the input channel stalls in turn.
// ============================================================================
module block_copy_run_coalescer_top
    import bcrc_pkg::*;
#(
    parameter int DEVICE_BLOCKS_PER_LAYER = 4096,
    parameter int HOST_BLOCKS_PER_LAYER   = 4096,
    parameter int MAX_RUN_BLOCKS          = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pair input
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_item,
    // descriptor output
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_item,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     in_accept;
    t_push    push;
    t_seg     q_head;
    t_qstat   q_stat;
    logic     q_pop;

    // ---------------- register file ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swap_out          <= 1'b0;
            r_cfg.block_bytes       <= BLOCK_BYTES_RST;
            r_cfg.device_layer      <= '0;
            r_cfg.host_layer        <= '0;
            r_cfg.key_device_base   <= '0;
            r_cfg.value_device_base <= '0;
            r_cfg.key_host_base     <= '0;
            r_cfg.value_host_base   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SWAP_OUT:     r_cfg.swap_out          <= pwdata[0];
                REG_BLOCK_BYTES:  r_cfg.block_bytes       <= pwdata[BB_W-1:0];
                REG_DEVICE_LAYER: r_cfg.device_layer      <= pwdata[LAYER_W-1:0];
                REG_HOST_LAYER:   r_cfg.host_layer        <= pwdata[LAYER_W-1:0];
                REG_KEY_DEV_BASE: r_cfg.key_device_base   <= pwdata[ADDR_W-1:0];
                REG_VAL_DEV_BASE: r_cfg.value_device_base <= pwdata[ADDR_W-1:0];
                REG_KEY_HST_BASE: r_cfg.key_host_base     <= pwdata[ADDR_W-1:0];
                REG_VAL_HST_BASE: r_cfg.value_host_base   <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SWAP_OUT:     prdata = APB_DW'(r_cfg.swap_out);
            REG_BLOCK_BYTES:  prdata = APB_DW'(r_cfg.block_bytes);
            REG_DEVICE_LAYER: prdata = APB_DW'(r_cfg.device_layer);
            REG_HOST_LAYER:   prdata = APB_DW'(r_cfg.host_layer);
            REG_KEY_DEV_BASE: prdata = APB_DW'(r_cfg.key_device_base);
            REG_VAL_DEV_BASE: prdata = APB_DW'(r_cfg.value_device_base);
            REG_KEY_HST_BASE: prdata = APB_DW'(r_cfg.key_host_base);
            REG_VAL_HST_BASE: prdata = APB_DW'(r_cfg.value_host_base);
            default:          prdata = '0;
        endcase
    end

    // ---------------- front: run tracking ----------------
    // a pair may close two segments at once, so keep room for two
    assign o_stall   = !q_stat.room;
    assign in_accept = i_valid && !o_stall;

    bcrc_front #(
        .MAX_RUN_BLOCKS (MAX_RUN_BLOCKS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_item),
        .o_push   (push)
    );

    bcrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // ---------------- back: descriptor generation ----------------
    bcrc_back #(
        .DEVICE_BLOCKS_PER_LAYER (DEVICE_BLOCKS_PER_LAYER),
        .HOST_BLOCKS_PER_LAYER   (HOST_BLOCKS_PER_LAYER)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (q_head),
        .i_nonempty (q_stat.nonempty),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

`ifndef SYNTH
    // queue occupancy never goes past its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= Q_CNT_W'(Q_DEPTH))
        else $error("segment queue overflow");

    // a taken key descriptor is followed right away by its value descriptor
    a_key_then_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_item.is_value) |=> (o_valid && o_item.is_value))
        else $error("value descriptor did not follow key");

    // end-of-item and end-of-list marks only ever sit on a value descriptor
    a_marks_on_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.item_last || o_item.list_done)) |-> o_item.is_value)
        else $error("last/done mark on key descriptor");

    // list end always closes the item as well
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.list_done) |-> o_item.item_last)
        else $error("list_done without item_last");
`endif

endmodule
